// ----- hdl/color_match_centroid_unit_assert.svh -----
// Assertion macros shared by the colour-match centroid checker
`ifndef COLOR_MATCH_CENTROID_UNIT_ASSERT_SVH
`define COLOR_MATCH_CENTROID_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while rst is high
`define CMC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while rst is high
`define CMC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/cmc_pkg.sv -----
// Shared widths, constants and register indexes of the colour-match centroid unit
package cmc_pkg;

   // field widths
   localparam int COLOR_W     = 8;
   localparam int THRESH_W    = 13;
   localparam int FWIDTH_W    = 11;
   localparam int COORD_OUT_W = 10;

   // accumulator widths
   localparam int SUM_W   = 40;
   localparam int COUNT_W = 21;
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // squarer: operand is wide enough for the threshold
   localparam int MULT_W = THRESH_W;
   localparam int PROD_W = 2 * MULT_W;
   localparam int DIST_W = 2 * COLOR_W + 2;
   localparam int DIST_SHIFT = 8;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = THRESH_W;

   localparam logic [CSR_ADDR_W-1:0] CSR_TARGET_RED     = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_TARGET_GREEN   = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_TARGET_BLUE    = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_MATCH_THRESHOLD = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_WIDTH    = 3'd4;

   // register reset values
   localparam logic [COLOR_W-1:0]  RST_TARGET_RED   = 8'd255;
   localparam logic [COLOR_W-1:0]  RST_TARGET_GREEN = 8'd182;
   localparam logic [COLOR_W-1:0]  RST_TARGET_BLUE  = 8'd193;
   localparam logic [THRESH_W-1:0] RST_THRESHOLD    = 13'd40;
   localparam logic [FWIDTH_W-1:0] RST_FRAME_WIDTH  = 11'd640;

   // default frame limits
   localparam int DEFAULT_MAX_WIDTH  = 1024;
   localparam int DEFAULT_MAX_HEIGHT = 1024;

endpackage

// ----- hdl/color_match_centroid_unit.sv -----
// Colour-threshold blob centroid tracker, top level
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  red, green, blue, end_of_frame
//   rsp_      out        rsp_valid/rsp_stall  mask_pixel, frame_done, target_found,
//                                             centroid_x, centroid_y
//   csr_      in         csr_write            csr_index, csr_data
//
// A request goes through accept, five squarer steps (three colour differences,
// the threshold, a latch step), compare and deliver before the next acceptance.
// An end-of-frame request with matches adds two divider passes (40 steps each),
// using the shared restoring divider for the column mean, then the row mean.
// Reset is synchronous and returns the counters, sums and registers to defaults.
// A stalled result is held; the next request is taken while it waits.
module color_match_centroid_unit #(
   parameter int MAX_WIDTH  = cmc_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = cmc_pkg::DEFAULT_MAX_HEIGHT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [cmc_pkg::COLOR_W-1:0]       req_red,
   input  logic [cmc_pkg::COLOR_W-1:0]       req_green,
   input  logic [cmc_pkg::COLOR_W-1:0]       req_blue,
   input  logic                              req_end_of_frame,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_mask_pixel,
   output logic                              rsp_frame_done,
   output logic                              rsp_target_found,
   output logic [cmc_pkg::COORD_OUT_W-1:0]   rsp_centroid_x,
   output logic [cmc_pkg::COORD_OUT_W-1:0]   rsp_centroid_y,
   input  logic                              csr_write,
   input  logic [cmc_pkg::CSR_ADDR_W-1:0]    csr_index,
   input  logic [cmc_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int CMP_W = (COL_W + 1 > cmc_pkg::FWIDTH_W) ? COL_W + 1 : cmc_pkg::FWIDTH_W;

   // sequencer states
   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_SQUARE  = 3'd1;
   localparam logic [2:0] ST_COMPARE = 3'd2;
   localparam logic [2:0] ST_DIV_X   = 3'd3;
   localparam logic [2:0] ST_DIV_Y   = 3'd4;
   localparam logic [2:0] ST_DELIVER = 3'd5;

   localparam logic [2:0] STEP_RED    = 3'd0;
   localparam logic [2:0] STEP_GREEN  = 3'd1;
   localparam logic [2:0] STEP_BLUE   = 3'd2;
   localparam logic [2:0] STEP_THRESH = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [2:0] step_ff, step_in;

   // configuration registers
   logic [cmc_pkg::COLOR_W-1:0]  tgt_red_ff, tgt_green_ff, tgt_blue_ff;
   logic [cmc_pkg::THRESH_W-1:0] threshold_ff;
   logic [cmc_pkg::FWIDTH_W-1:0] frame_width_ff;

   // request payload
   logic [cmc_pkg::COLOR_W-1:0] red_ff, red_in, green_ff, green_in, blue_ff, blue_in;
   logic                        eof_ff, eof_in;

   // arithmetic
   logic [cmc_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic [cmc_pkg::DIST_W-1:0] dist_ff, dist_in;
   logic [cmc_pkg::PROD_W-1:0] thr_sq_ff, thr_sq_in;
   logic [cmc_pkg::MULT_W-1:0] mul_op;
   logic [cmc_pkg::COLOR_W-1:0] diff_val, diff_a, diff_b;
   logic                       match;

   // frame state
   logic [COL_W-1:0]            col_ff, col_in;
   logic [ROW_W-1:0]            row_ff, row_in;
   logic [cmc_pkg::SUM_W-1:0]   sum_col_ff, sum_col_in, sum_row_ff, sum_row_in;
   logic [cmc_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [CMP_W-1:0]            limit;

   // result fields
   logic                            match_ff, match_in;
   logic                            found_ff, found_in;
   logic [cmc_pkg::COORD_OUT_W-1:0] cx_ff, cx_in, cy_ff, cy_in;

   // result register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_mask_ff, rsp_mask_in;
   logic                            rsp_done_ff, rsp_done_in;
   logic                            rsp_found_ff, rsp_found_in;
   logic [cmc_pkg::COORD_OUT_W-1:0] rsp_cx_ff, rsp_cx_in, rsp_cy_ff, rsp_cy_in;

   // divider hookup
   logic                        div_start;
   logic                        div_done;
   logic [cmc_pkg::SUM_W-1:0]   div_dividend;
   logic [cmc_pkg::SUM_W-1:0]   div_quotient;

   cmc_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (count_in),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign div_dividend = (state_ff == ST_COMPARE) ? sum_col_in : sum_row_ff;

   // operand select for the shared squarer
   always_comb begin
      case (step_ff)
         STEP_RED: begin
            diff_a = red_ff;
            diff_b = tgt_red_ff;
         end
         STEP_GREEN: begin
            diff_a = green_ff;
            diff_b = tgt_green_ff;
         end
         default: begin
            diff_a = blue_ff;
            diff_b = tgt_blue_ff;
         end
      endcase
      diff_val = (diff_a >= diff_b) ? (diff_a - diff_b) : (diff_b - diff_a);
      if (step_ff == STEP_RED || step_ff == STEP_GREEN || step_ff == STEP_BLUE) begin
         mul_op = cmc_pkg::MULT_W'(diff_val);
      end else begin
         mul_op = threshold_ff;
      end
   end

   // squared distance against squared threshold
   assign match = {dist_ff, {cmc_pkg::DIST_SHIFT{1'b0}}} < thr_sq_ff;

   // effective row length
   assign limit = (CMP_W'(frame_width_ff) > CMP_W'(MAX_WIDTH)) ?
                  CMP_W'(MAX_WIDTH) : CMP_W'(frame_width_ff);

   assign req_stall = (state_ff != ST_IDLE);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      red_in       = red_ff;
      green_in     = green_ff;
      blue_in      = blue_ff;
      eof_in       = eof_ff;
      prod_in      = mul_op * mul_op;
      dist_in      = dist_ff;
      thr_sq_in    = thr_sq_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      sum_col_in   = sum_col_ff;
      sum_row_in   = sum_row_ff;
      count_in     = count_ff;
      match_in     = match_ff;
      found_in     = found_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      div_start    = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_mask_in  = rsp_mask_ff;
      rsp_done_in  = rsp_done_ff;
      rsp_found_in = rsp_found_ff;
      rsp_cx_in    = rsp_cx_ff;
      rsp_cy_in    = rsp_cy_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               red_in   = req_red;
               green_in = req_green;
               blue_in  = req_blue;
               eof_in   = req_end_of_frame;
               step_in  = STEP_RED;
               dist_in  = '0;
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            // accumulate the square computed in the previous step
            if (step_ff == STEP_THRESH) begin
               thr_sq_in = prod_ff;
               state_in  = ST_COMPARE;
            end else if (step_ff != STEP_RED) begin
               dist_in = dist_ff + cmc_pkg::DIST_W'(prod_ff);
            end
            step_in = step_ff + 1'b1;
         end
         ST_COMPARE: begin
            match_in = match;
            found_in = 1'b0;
            cx_in    = '0;
            cy_in    = '0;
            if (match && count_ff != cmc_pkg::COUNT_MAX) begin
               sum_col_in = sum_col_ff + cmc_pkg::SUM_W'(col_ff);
               sum_row_in = sum_row_ff + cmc_pkg::SUM_W'(row_ff);
               count_in   = count_ff + 1'b1;
            end
            if (eof_ff && count_in != '0) begin
               div_start = 1'b1;
               state_in  = ST_DIV_X;
            end else begin
               state_in = ST_DELIVER;
            end
         end
         ST_DIV_X: begin
            if (div_done) begin
               cx_in     = div_quotient[cmc_pkg::COORD_OUT_W-1:0];
               div_start = 1'b1;
               state_in  = ST_DIV_Y;
            end
         end
         ST_DIV_Y: begin
            if (div_done) begin
               cy_in    = div_quotient[cmc_pkg::COORD_OUT_W-1:0];
               found_in = 1'b1;
               state_in = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_mask_in  = match_ff;
               rsp_done_in  = eof_ff;
               rsp_found_in = found_ff;
               rsp_cx_in    = cx_ff;
               rsp_cy_in    = cy_ff;
               if (eof_ff) begin
                  col_in     = '0;
                  row_in     = '0;
                  sum_col_in = '0;
                  sum_row_in = '0;
                  count_in   = '0;
               end else if (CMP_W'(col_ff) + 1'b1 >= limit) begin
                  col_in = '0;
                  if ((ROW_W + 1)'(row_ff) + 1'b1 >= (ROW_W + 1)'(MAX_HEIGHT)) begin
                     row_in = '0;
                  end else begin
                     row_in = row_ff + 1'b1;
                  end
               end else begin
                  col_in = col_ff + 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         step_ff        <= STEP_RED;
         col_ff         <= '0;
         row_ff         <= '0;
         sum_col_ff     <= '0;
         sum_row_ff     <= '0;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         tgt_red_ff     <= cmc_pkg::RST_TARGET_RED;
         tgt_green_ff   <= cmc_pkg::RST_TARGET_GREEN;
         tgt_blue_ff    <= cmc_pkg::RST_TARGET_BLUE;
         threshold_ff   <= cmc_pkg::RST_THRESHOLD;
         frame_width_ff <= cmc_pkg::RST_FRAME_WIDTH;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         sum_col_ff   <= sum_col_in;
         sum_row_ff   <= sum_row_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            unique case (csr_index)
               cmc_pkg::CSR_TARGET_RED: begin
                  tgt_red_ff <= csr_data[cmc_pkg::COLOR_W-1:0];
               end
               cmc_pkg::CSR_TARGET_GREEN: begin
                  tgt_green_ff <= csr_data[cmc_pkg::COLOR_W-1:0];
               end
               cmc_pkg::CSR_TARGET_BLUE: begin
                  tgt_blue_ff <= csr_data[cmc_pkg::COLOR_W-1:0];
               end
               cmc_pkg::CSR_MATCH_THRESHOLD: begin
                  threshold_ff <= csr_data;
               end
               cmc_pkg::CSR_FRAME_WIDTH: begin
                  frame_width_ff <= csr_data[cmc_pkg::FWIDTH_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      red_ff       <= red_in;
      green_ff     <= green_in;
      blue_ff      <= blue_in;
      eof_ff       <= eof_in;
      prod_ff      <= prod_in;
      dist_ff      <= dist_in;
      thr_sq_ff    <= thr_sq_in;
      match_ff     <= match_in;
      found_ff     <= found_in;
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      rsp_mask_ff  <= rsp_mask_in;
      rsp_done_ff  <= rsp_done_in;
      rsp_found_ff <= rsp_found_in;
      rsp_cx_ff    <= rsp_cx_in;
      rsp_cy_ff    <= rsp_cy_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mask_pixel   = rsp_mask_ff;
   assign rsp_frame_done   = rsp_done_ff;
   assign rsp_target_found = rsp_found_ff;
   assign rsp_centroid_x   = rsp_cx_ff;
   assign rsp_centroid_y   = rsp_cy_ff;

endmodule

// ----- hdl/cmc_divider.sv -----
// Restoring divider, one quotient bit per cycle
module cmc_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [cmc_pkg::SUM_W-1:0]     dividend,
   input  logic [cmc_pkg::COUNT_W-1:0]   divisor,
   output logic                          done,
   output logic [cmc_pkg::SUM_W-1:0]     quotient
);

   localparam int CNT_W = $clog2(cmc_pkg::SUM_W + 1);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [cmc_pkg::SUM_W-1:0]     dq_ff, dq_in;
   logic [cmc_pkg::COUNT_W-1:0]   rem_ff, rem_in;
   logic [cmc_pkg::COUNT_W-1:0]   dvs_ff, dvs_in;
   logic [cmc_pkg::COUNT_W:0]     shifted;
   logic                          fits;

   // one trial subtraction
   assign shifted = {rem_ff, dq_ff[cmc_pkg::SUM_W-1]};
   assign fits    = shifted >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(cmc_pkg::SUM_W);
         dq_in   = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = cmc_pkg::COUNT_W'(shifted - {1'b0, dvs_ff});
         end else begin
            rem_in = shifted[cmc_pkg::COUNT_W-1:0];
         end
         dq_in  = {dq_ff[cmc_pkg::SUM_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = dq_ff;

endmodule

// ----- hdl/cmc_checker.sv -----
// Port-level checks for the colour-match centroid unit, bound to the top level
`include "color_match_centroid_unit_assert.svh"

module cmc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic                              rsp_frame_done,
   input logic                              rsp_target_found,
   input logic [cmc_pkg::COORD_OUT_W-1:0]   rsp_centroid_x,
   input logic [cmc_pkg::COORD_OUT_W-1:0]   rsp_centroid_y
);

   // no result straight out of reset
   `CMC_ASSERT_NEXT(a_reset_clears_rsp, clock, 1'b0, reset, !rsp_valid, "result valid after reset")

   // a taken request keeps the unit busy for at least the next cycle
   `CMC_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && !req_stall, req_stall, "request taken back to back")

   // centroid fields are zero except on a frame end with matches
   `CMC_ASSERT_IMPLY(a_mid_frame_zero, clock, reset, rsp_valid && !rsp_frame_done, !rsp_target_found && rsp_centroid_x == '0 && rsp_centroid_y == '0, "centroid set mid frame")

   `CMC_ASSERT_IMPLY(a_not_found_zero, clock, reset, rsp_valid && !rsp_target_found, rsp_centroid_x == '0 && rsp_centroid_y == '0, "centroid set without match")

   // a stalled result stays put
   `CMC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_centroid_x) && $stable(rsp_centroid_y), "stalled result changed")

endmodule

bind color_match_centroid_unit cmc_checker u_cmc_checker (.*);

// ----- test/tb_color_match_centroid_unit.sv -----
// Self-checking testbench for the colour-match centroid unit, with a built-in centroid predictor
`timescale 1ns / 100ps

module tb_color_match_centroid_unit;

   localparam int CLK_PERIOD   = 8;
   localparam int LIMIT_CYCLES = 1_000_000;
   localparam int DRAIN_CYCLES = 120;   // covers two divider passes and delivery
   localparam int MAX_COL      = cmc_pkg::DEFAULT_MAX_WIDTH;
   localparam int MAX_ROW      = cmc_pkg::DEFAULT_MAX_HEIGHT;
   localparam logic [cmc_pkg::THRESH_W-1:0] THRESH_MAX = '1;
   localparam logic [cmc_pkg::FWIDTH_W-1:0] WIDTH_MAX  = '1;

   typedef struct packed {
      logic                            mask;
      logic                            done;
      logic                            found;
      logic [cmc_pkg::COORD_OUT_W-1:0] cx;
      logic [cmc_pkg::COORD_OUT_W-1:0] cy;
   } centroid_result_type;

   typedef struct packed {
      logic [cmc_pkg::COLOR_W-1:0] red, green, blue;
      logic                        eof;
      logic                        typed;   // use the result below instead of the predictor
      centroid_result_type         want;
   } pixel_row_type;

   localparam centroid_result_type NO_RESULT = '0;

   // directed pixels, default registers (target 255/182/193, threshold 2.5, width 640)
   localparam int N_DIRECTED = 16;
   localparam pixel_row_type DIRECTED_ROWS [N_DIRECTED] = '{
      // exact target colour matches; no centroid before frame end
      '{8'd255, 8'd182, 8'd193, 1'b0, 1'b1, '{1'b1, 1'b0, 1'b0, 10'd0, 10'd0}},
      '{8'd0,   8'd0,   8'd0,   1'b0, 1'b1, NO_RESULT},
      '{8'd255, 8'd255, 8'd255, 1'b0, 1'b1, NO_RESULT},
      // around the threshold: squared distance 1 and 6 inside, 8 outside
      '{8'd255, 8'd183, 8'd193, 1'b0, 1'b0, NO_RESULT},
      '{8'd254, 8'd181, 8'd191, 1'b0, 1'b0, NO_RESULT},
      '{8'd255, 8'd180, 8'd191, 1'b0, 1'b0, NO_RESULT},
      '{8'd0,   8'd255, 8'd0,   1'b0, 1'b0, NO_RESULT},
      '{8'd255, 8'd0,   8'd255, 1'b0, 1'b0, NO_RESULT},
      '{8'd128, 8'd128, 8'd128, 1'b1, 1'b0, NO_RESULT},
      // one-pixel frame matching at the origin
      '{8'd255, 8'd182, 8'd193, 1'b1, 1'b1, '{1'b1, 1'b1, 1'b1, 10'd0, 10'd0}},
      // frame with no match at all
      '{8'd0,   8'd0,   8'd0,   1'b0, 1'b1, NO_RESULT},
      '{8'd255, 8'd255, 8'd255, 1'b1, 1'b1, '{1'b0, 1'b1, 1'b0, 10'd0, 10'd0}},
      // frame end on a matching pixel, which counts itself
      '{8'd255, 8'd182, 8'd192, 1'b0, 1'b0, NO_RESULT},
      '{8'd1,   8'd2,   8'd3,   1'b0, 1'b0, NO_RESULT},
      '{8'd255, 8'd182, 8'd193, 1'b0, 1'b0, NO_RESULT},
      '{8'd254, 8'd183, 8'd194, 1'b1, 1'b0, NO_RESULT}
   };

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic [cmc_pkg::COLOR_W-1:0]     req_red = '0;
   logic [cmc_pkg::COLOR_W-1:0]     req_green = '0;
   logic [cmc_pkg::COLOR_W-1:0]     req_blue = '0;
   logic                            req_end_of_frame = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic                            rsp_mask_pixel;
   logic                            rsp_frame_done;
   logic                            rsp_target_found;
   logic [cmc_pkg::COORD_OUT_W-1:0] rsp_centroid_x;
   logic [cmc_pkg::COORD_OUT_W-1:0] rsp_centroid_y;
   logic                            csr_write = 1'b0;
   logic [cmc_pkg::CSR_ADDR_W-1:0]  csr_index = '0;
   logic [cmc_pkg::CSR_DATA_W-1:0]  csr_data = '0;

   // predictor copy of registers and frame state
   logic [cmc_pkg::COLOR_W-1:0]     tgt_red, tgt_green, tgt_blue;
   logic [cmc_pkg::THRESH_W-1:0]    thresh;
   logic [cmc_pkg::FWIDTH_W-1:0]    row_len;
   logic [cmc_pkg::COORD_OUT_W-1:0] col_pos, row_pos;
   logic [cmc_pkg::SUM_W-1:0]       col_sum, row_sum;
   logic [cmc_pkg::COUNT_W-1:0]     hit_count;

   centroid_result_type pending_results[$];
   int mismatch_count = 0;
   int send_idle_pct  = 0;
   int rsp_stall_pct  = 0;

   color_match_centroid_unit uut (.*);

   always #(CLK_PERIOD / 2) clock = ~clock;

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   task automatic report_mismatch(input string msg);
      $display("%0t ns  mismatch  %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [cmc_pkg::COORD_OUT_W-1:0] got,
                              input logic [cmc_pkg::COORD_OUT_W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s: got %0d, want %0d", name, got, want));
   endtask

   task automatic check_flag(input string name, input logic got, input logic want);
      if (got !== want)
         report_mismatch($sformatf("%s: got %0b, want %0b", name, got, want));
   endtask

   // compare each delivered result with the oldest outstanding one
   always @(posedge clock) begin
      centroid_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with no request outstanding");
         end else begin
            want = pending_results.pop_front();
            check_flag("mask_pixel", rsp_mask_pixel, want.mask);
            check_flag("frame_done", rsp_frame_done, want.done);
            check_flag("target_found", rsp_target_found, want.found);
            check_field("centroid_x", rsp_centroid_x, want.cx);
            check_field("centroid_y", rsp_centroid_y, want.cy);
         end
      end
   end

   function automatic logic [2*cmc_pkg::COLOR_W-1:0] diff_sq(
         input logic [cmc_pkg::COLOR_W-1:0] a, input logic [cmc_pkg::COLOR_W-1:0] b);
      logic [2*cmc_pkg::COLOR_W-1:0] d;
      d = (a >= b) ? (2*cmc_pkg::COLOR_W)'(a - b) : (2*cmc_pkg::COLOR_W)'(b - a);
      return d * d;
   endfunction

   function automatic logic [cmc_pkg::COLOR_W-1:0] pick_level();
      return $urandom_range(1) ? 8'hFF : 8'h00;
   endfunction

   function automatic logic [cmc_pkg::COLOR_W-1:0] jitter(
         input logic [cmc_pkg::COLOR_W-1:0] c, input int k);
      int v;
      v = int'(c) + int'($urandom_range(2 * k)) - k;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return cmc_pkg::COLOR_W'(v);
   endfunction

   task automatic clear_frame();
      col_pos   = '0;
      row_pos   = '0;
      col_sum   = '0;
      row_sum   = '0;
      hit_count = '0;
   endtask

   // predict the result of one pixel and advance the frame state
   task automatic track_pixel(input logic [cmc_pkg::COLOR_W-1:0] r, g, b, input logic eof,
                              output centroid_result_type res);
      logic [cmc_pkg::DIST_W-1:0] dist2;
      logic [cmc_pkg::PROD_W-1:0] thr_sq;
      logic [cmc_pkg::PROD_W-1:0] scaled;
      logic                       hit;
      int                         limit;
      dist2  = cmc_pkg::DIST_W'(diff_sq(r, tgt_red)) + cmc_pkg::DIST_W'(diff_sq(g, tgt_green))
               + cmc_pkg::DIST_W'(diff_sq(b, tgt_blue));
      thr_sq = cmc_pkg::PROD_W'(thresh) * cmc_pkg::PROD_W'(thresh);
      scaled = {dist2, {cmc_pkg::DIST_SHIFT{1'b0}}};
      hit    = scaled < thr_sq;
      // saturated count freezes the sums
      if (hit && hit_count != cmc_pkg::COUNT_MAX) begin
         col_sum   = col_sum + cmc_pkg::SUM_W'(col_pos);
         row_sum   = row_sum + cmc_pkg::SUM_W'(row_pos);
         hit_count = hit_count + 1'b1;
      end
      res      = '0;
      res.mask = hit;
      res.done = eof;
      if (eof) begin
         if (hit_count != 0) begin
            res.found = 1'b1;
            res.cx    = cmc_pkg::COORD_OUT_W'(col_sum / hit_count);
            res.cy    = cmc_pkg::COORD_OUT_W'(row_sum / hit_count);
         end
         clear_frame();
      end else begin
         // width zero acts as one; widths past the maximum wrap at the maximum
         limit = (int'(row_len) > MAX_COL) ? MAX_COL : int'(row_len);
         if (int'(col_pos) + 1 >= limit) begin
            col_pos = '0;
            row_pos = (int'(row_pos) + 1 >= MAX_ROW) ? '0 : row_pos + 1'b1;
         end else begin
            col_pos = col_pos + 1'b1;
         end
      end
   endtask

   task automatic write_csr(input logic [cmc_pkg::CSR_ADDR_W-1:0] idx,
                            input logic [cmc_pkg::CSR_DATA_W-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      case (idx)
         cmc_pkg::CSR_TARGET_RED:      tgt_red   = val[cmc_pkg::COLOR_W-1:0];
         cmc_pkg::CSR_TARGET_GREEN:    tgt_green = val[cmc_pkg::COLOR_W-1:0];
         cmc_pkg::CSR_TARGET_BLUE:     tgt_blue  = val[cmc_pkg::COLOR_W-1:0];
         cmc_pkg::CSR_MATCH_THRESHOLD: thresh    = val[cmc_pkg::THRESH_W-1:0];
         cmc_pkg::CSR_FRAME_WIDTH:     row_len   = val[cmc_pkg::FWIDTH_W-1:0];
         default: ;
      endcase
   endtask

   task automatic program_regs(input logic [cmc_pkg::COLOR_W-1:0] r, g, b,
                               input logic [cmc_pkg::THRESH_W-1:0] thr,
                               input logic [cmc_pkg::FWIDTH_W-1:0] w);
      write_csr(cmc_pkg::CSR_TARGET_RED, cmc_pkg::CSR_DATA_W'(r));
      write_csr(cmc_pkg::CSR_TARGET_GREEN, cmc_pkg::CSR_DATA_W'(g));
      write_csr(cmc_pkg::CSR_TARGET_BLUE, cmc_pkg::CSR_DATA_W'(b));
      write_csr(cmc_pkg::CSR_MATCH_THRESHOLD, thr);
      write_csr(cmc_pkg::CSR_FRAME_WIDTH, cmc_pkg::CSR_DATA_W'(w));
      csr_write <= 1'b0;
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
         1: begin send_idle_pct = 55; rsp_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  rsp_stall_pct = 55; end
         default: begin send_idle_pct = 11; rsp_stall_pct = 11; end
      endcase
   endtask

   // hold off requests until every outstanding result has been delivered
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic send_pixel(input logic [cmc_pkg::COLOR_W-1:0] r, g, b, input logic eof,
                             input logic typed, input centroid_result_type want);
      centroid_result_type res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_red          <= r;
      req_green        <= g;
      req_blue         <= b;
      req_end_of_frame <= eof;
      do @(posedge clock); while (req_stall);
      track_pixel(r, g, b, eof, res);
      pending_results.push_back(typed ? want : res);
   endtask

   // one frame of random pixels, mostly close to the target colour
   task automatic send_frame(input int n_pix);
      logic [cmc_pkg::COLOR_W-1:0] r, g, b;
      int k;
      for (int i = 0; i < n_pix; i++) begin
         if ($urandom_range(59) == 0)
            wait_for_results();
         case ($urandom_range(9))
            0: begin r = pick_level(); g = pick_level(); b = pick_level(); end
            1, 2, 3: begin
               r = cmc_pkg::COLOR_W'($urandom);
               g = cmc_pkg::COLOR_W'($urandom);
               b = cmc_pkg::COLOR_W'($urandom);
            end
            default: begin
               k = $urandom_range(40);
               r = jitter(tgt_red, k);
               g = jitter(tgt_green, k);
               b = jitter(tgt_blue, k);
            end
         endcase
         send_pixel(r, g, b, i == n_pix - 1, 1'b0, NO_RESULT);
      end
   endtask

   initial begin
      #(LIMIT_CYCLES * CLK_PERIOD);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      logic [cmc_pkg::COLOR_W-1:0]  cfg_red, cfg_green, cfg_blue;
      logic [cmc_pkg::THRESH_W-1:0] cfg_thr;
      logic [cmc_pkg::FWIDTH_W-1:0] cfg_width;
      int sent, n_pix, guard;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      tgt_red   = cmc_pkg::RST_TARGET_RED;
      tgt_green = cmc_pkg::RST_TARGET_GREEN;
      tgt_blue  = cmc_pkg::RST_TARGET_BLUE;
      thresh    = cmc_pkg::RST_THRESHOLD;
      row_len   = cmc_pkg::RST_FRAME_WIDTH;
      clear_frame();

      // directed requests on the reset registers
      for (int i = 0; i < N_DIRECTED; i++)
         send_pixel(DIRECTED_ROWS[i].red, DIRECTED_ROWS[i].green, DIRECTED_ROWS[i].blue,
                    DIRECTED_ROWS[i].eof, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
      wait_for_results();

      // zero threshold: even the exact target colour misses
      set_idling(1);
      program_regs(cmc_pkg::RST_TARGET_RED, cmc_pkg::RST_TARGET_GREEN,
                   cmc_pkg::RST_TARGET_BLUE, '0, cmc_pkg::RST_FRAME_WIDTH);
      for (int i = 0; i < 6; i++)
         send_pixel(tgt_red, tgt_green, tgt_blue, i == 5, 1'b0, NO_RESULT);
      wait_for_results();

      // full threshold, everything matches; zero width steps the row every pixel
      set_idling(2);
      program_regs('0, '0, '0, THRESH_MAX, '0);
      send_frame(20);
      wait_for_results();

      // random phases, each with fresh registers and one of four idling patterns
      for (int phase = 0; phase < 8; phase++) begin
         cfg_red   = ($urandom_range(3) == 0) ? pick_level() : cmc_pkg::COLOR_W'($urandom);
         cfg_green = ($urandom_range(3) == 0) ? pick_level() : cmc_pkg::COLOR_W'($urandom);
         cfg_blue  = ($urandom_range(3) == 0) ? pick_level() : cmc_pkg::COLOR_W'($urandom);
         case ($urandom_range(9))
            0: cfg_thr = '0;
            1: cfg_thr = THRESH_MAX;
            2, 3: cfg_thr = cmc_pkg::THRESH_W'($urandom_range(THRESH_MAX));
            default: cfg_thr = cmc_pkg::THRESH_W'($urandom_range(16, 1200));
         endcase
         case ($urandom_range(9))
            0: cfg_width = '0;
            1: cfg_width = cmc_pkg::FWIDTH_W'(MAX_COL);
            2: cfg_width = cmc_pkg::FWIDTH_W'($urandom_range(MAX_COL + 1, WIDTH_MAX));
            3: cfg_width = cmc_pkg::RST_FRAME_WIDTH;
            default: cfg_width = cmc_pkg::FWIDTH_W'($urandom_range(1, 16));
         endcase
         program_regs(cfg_red, cfg_green, cfg_blue, cfg_thr, cfg_width);
         set_idling(phase % 4);
         sent = 0;
         while (sent < 70) begin
            n_pix = $urandom_range(1, 30);
            send_frame(n_pix);
            sent += n_pix;
         end
         wait_for_results();
      end

      // final drain, then a quiet spell to catch stray results
      req_valid <= 1'b0;
      for (guard = 0; guard < 20000 && pending_results.size() != 0; guard++)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch($sformatf("%0d results never delivered", pending_results.size()));

      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
